/* rtl/lir_pkg.sv */
// Shared types and constants for the linear interpolation resampler.
`default_nettype none

package lir_pkg;

    // Field widths of the transactions and of the configuration register.
    localparam int SAMPLE_W          = 16;
    localparam int CFG_W             = 21;
    localparam int FRACTION_BITS_DEF = 16;

    // Phase step after reset: a ratio of 1.0 in unsigned 5.16.
    localparam logic [CFG_W-1:0] PHASE_STEP_RESET = CFG_W'(65536);

    // Queue depths between the front, the back and the result port.
    localparam int WORK_DEPTH = 2;
    localparam int OUT_DEPTH  = 4;

    // One input transaction.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       chunk_last;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       run_last;
        logic                       chunk_done;
    } t_out_item;

    // Sequencer states of the back part.
    typedef enum logic [1:0] {
        S_IDLE,
        S_INTERP,
        S_TAIL
    } t_state;

endpackage

`default_nettype wire

/* rtl/lir_front.sv */
// Front part: configuration register, step clamp and the work queue to the back.
`default_nettype none

module lir_front
    import lir_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int STEP_W       = FRACTION_BITS + 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic              push,
    output logic                   full,
    input  wire t_in_item          i_in_item,
    output logic                   o_work_valid,
    input  wire logic              i_work_pop,
    output t_in_item               o_work_item,
    output logic [STEP_W-1:0]      o_work_step
);

    localparam int CMP_W = (CFG_W > STEP_W) ? CFG_W : STEP_W;
    localparam logic [CMP_W-1:0] STEP_MIN = CMP_W'(1) << (FRACTION_BITS - 4);
    localparam logic [CMP_W-1:0] STEP_MAX = CMP_W'(1) << (FRACTION_BITS + 4);
    localparam logic [CMP_W-1:0] STEP_ONE = CMP_W'(1) << FRACTION_BITS;
    localparam int PTR_W = $clog2(WORK_DEPTH);
    localparam int CNT_W = $clog2(WORK_DEPTH + 1);

    logic [CFG_W-1:0]  r_phase_step;
    logic [CMP_W-1:0]  step_ext;
    logic [STEP_W-1:0] step_clamped;

    t_in_item          r_q_item [WORK_DEPTH];
    logic [STEP_W-1:0] r_q_step [WORK_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push_ok;
    logic              pop_ok;

    // The phase step register is written whenever the write enable is high.
    // After reset it holds a ratio of 1.0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= CFG_W'(STEP_ONE);
        end else if (i_cfg_wr_en) begin
            r_phase_step <= i_cfg_wr_data;
        end
    end

    // Clamp the step so that a tiny or huge value cannot stall the sequencer.
    always_comb begin
        step_ext = CMP_W'(r_phase_step);
        if (step_ext < STEP_MIN) begin
            step_clamped = STEP_W'(STEP_MIN);
        end else if (step_ext > STEP_MAX) begin
            step_clamped = STEP_W'(STEP_MAX);
        end else begin
            step_clamped = STEP_W'(step_ext);
        end
    end

    assign full         = (r_count == CNT_W'(WORK_DEPTH));
    assign push_ok      = push && !full;
    assign pop_ok       = i_work_pop && (r_count != '0);
    assign o_work_valid = (r_count != '0);
    assign o_work_item  = r_q_item[r_rd_ptr];
    assign o_work_step  = r_q_step[r_rd_ptr];

    // Queue storage: each accepted transaction is stored with its clamped step.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q_item[r_wr_ptr] <= i_in_item;
            r_q_step[r_wr_ptr] <= step_clamped;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= PTR_W'((32'(r_wr_ptr) + 1) % WORK_DEPTH);
            end
            if (pop_ok) begin
                r_rd_ptr <= PTR_W'((32'(r_rd_ptr) + 1) % WORK_DEPTH);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/lir_back.sv */
// Back part: sequencer that emits the interpolated results of one sample at a time.
`default_nettype none

module lir_back
    import lir_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int STEP_W       = FRACTION_BITS + 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_work_valid,
    output logic                   o_work_pop,
    input  wire t_in_item          i_work_item,
    input  wire logic [STEP_W-1:0] i_work_step,
    output logic                   o_emit,
    output t_out_item              o_result,
    input  wire logic              i_out_full
);

    localparam int POS_W  = FRACTION_BITS + 5;
    localparam int SUM_W  = FRACTION_BITS + 6;
    localparam int PROD_W = SAMPLE_W + FRACTION_BITS + 2;
    localparam logic [SUM_W-1:0] ONE_S = SUM_W'(1) << FRACTION_BITS;
    localparam logic [SUM_W-1:0] TWO_S = SUM_W'(1) << (FRACTION_BITS + 1);

    t_state                     r_state;
    t_state                     n_state;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [SAMPLE_W-1:0] n_prev;
    logic                       r_have_prev;
    logic                       n_have_prev;
    logic [POS_W-1:0]           r_pos;
    logic [POS_W-1:0]           n_pos;
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_last;
    logic [STEP_W-1:0]          r_step;

    logic [SUM_W-1:0]           pos_s;
    logic [SUM_W-1:0]           step_s;
    logic [SUM_W-1:0]           pos_next;
    logic [SUM_W-1:0]           pos_look;
    logic                       interp_ok;
    logic                       interp_fin;
    logic                       tail_ok;
    logic                       tail_fin;
    logic                       take;

    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_sh;
    logic signed [SAMPLE_W+1:0] interp_sum;
    logic signed [SAMPLE_W-1:0] interp_val;

    // Position arithmetic shared by both emitting states.
    assign pos_s    = SUM_W'(r_pos);
    assign step_s   = SUM_W'(r_step);
    assign pos_next = pos_s + step_s;
    assign pos_look = pos_next + step_s;

    // Interpolation runs while the position lies inside the sample interval;
    // on the chunk's last sample it stops where the next output would pass the end.
    assign interp_ok  = (pos_s < ONE_S) && !(r_last && (pos_next > TWO_S));
    assign interp_fin = r_last ? (pos_look > TWO_S) : (pos_next >= ONE_S);
    assign tail_ok    = (pos_next <= ONE_S);
    assign tail_fin   = (pos_look > ONE_S);

    assign take = (r_state == S_IDLE) && i_work_valid;

    // Interpolated value: prev + floor((x - prev) * frac / one).
    always_comb begin
        diff       = {r_x[SAMPLE_W-1], r_x} - {r_prev[SAMPLE_W-1], r_prev};
        prod       = PROD_W'(diff) * PROD_W'(signed'({1'b0, r_pos[FRACTION_BITS-1:0]}));
        prod_sh    = prod >>> FRACTION_BITS;
        interp_sum = (SAMPLE_W + 2)'(r_prev) + prod_sh[SAMPLE_W+1:0];
        interp_val = interp_sum[SAMPLE_W-1:0];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_work_valid) begin
                    if (r_have_prev) begin
                        n_state = S_INTERP;
                    end else if (i_work_item.chunk_last) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_INTERP: begin
                if (interp_ok) begin
                    if (!i_out_full) begin
                        if (interp_fin) begin
                            n_state = S_IDLE;
                        end else if (pos_next >= ONE_S) begin
                            n_state = S_TAIL;
                        end
                    end
                end else if ((pos_s >= ONE_S) && r_last) begin
                    n_state = S_TAIL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TAIL: begin
                if (!tail_ok || (!i_out_full && tail_fin)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath updates and result generation.
    always_comb begin
        n_prev              = r_prev;
        n_have_prev         = r_have_prev;
        n_pos               = r_pos;
        o_work_pop          = take;
        o_emit              = 1'b0;
        o_result.sample_out = interp_val;
        o_result.run_last   = 1'b0;
        o_result.chunk_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // First sample of a chunk only primes the previous sample.
                if (i_work_valid && !r_have_prev) begin
                    n_prev      = i_work_item.sample_in;
                    n_have_prev = 1'b1;
                end
            end
            S_INTERP: begin
                if (interp_ok) begin
                    if (!i_out_full) begin
                        o_emit              = 1'b1;
                        o_result.run_last   = interp_fin;
                        o_result.chunk_done = interp_fin && r_last;
                        if (interp_fin && r_last) begin
                            n_prev      = r_x;
                            n_have_prev = 1'b0;
                            n_pos       = '0;
                        end else if (pos_next >= ONE_S) begin
                            n_prev = r_x;
                            n_pos  = POS_W'(pos_next - ONE_S);
                        end else begin
                            n_pos = POS_W'(pos_next);
                        end
                    end
                end else if (pos_s >= ONE_S) begin
                    // No output falls in this interval.
                    n_prev = r_x;
                    n_pos  = POS_W'(pos_s - ONE_S);
                end else begin
                    // Last sample with the next output past the chunk end.
                    n_prev      = r_x;
                    n_have_prev = 1'b0;
                    n_pos       = '0;
                end
            end
            S_TAIL: begin
                o_result.sample_out = r_x;
                if (!tail_ok) begin
                    n_have_prev = 1'b0;
                    n_pos       = '0;
                end else if (!i_out_full) begin
                    o_emit              = 1'b1;
                    o_result.run_last   = tail_fin;
                    o_result.chunk_done = tail_fin;
                    if (tail_fin) begin
                        n_have_prev = 1'b0;
                        n_pos       = '0;
                    end else begin
                        n_pos = POS_W'(pos_next);
                    end
                end
            end
            default: begin
                o_work_pop = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            r_pos       <= n_pos;
        end
    end

    // The current transaction is held while its results are produced.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x    <= i_work_item.sample_in;
            r_last <= i_work_item.chunk_last;
            r_step <= i_work_step;
        end
    end

endmodule

`default_nettype wire

/* rtl/lir_out_fifo.sv */
// Result queue that decouples the sequencer from the consumer.
`default_nettype none

module lir_out_fifo
    import lir_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_wr_en,
    input  wire t_out_item i_wr_item,
    output logic           o_full,
    output logic           empty,
    input  wire logic      pop,
    output t_out_item      o_out_item
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    t_out_item        r_mem [OUT_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_ok;
    logic             rd_ok;

    assign o_full     = (r_count == CNT_W'(OUT_DEPTH));
    assign empty      = (r_count == '0);
    assign wr_ok      = i_wr_en && !o_full;
    assign rd_ok      = pop && !empty;
    assign o_out_item = r_mem[r_rd_ptr];

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= PTR_W'((32'(r_wr_ptr) + 1) % OUT_DEPTH);
            end
            if (rd_ok) begin
                r_rd_ptr <= PTR_W'((32'(r_rd_ptr) + 1) % OUT_DEPTH);
            end
            if (wr_ok && !rd_ok) begin
                r_count <= r_count + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/linear_interp_resampler.sv */
// Top level of the linear interpolation resampler.
//
// Resamples chunks of signed 16-bit audio by linear interpolation with a 5.16
// phase step (input rate over output rate), clamped to 1/16 through 16. Input
// samples enter a two-entry queue; a sequencer then takes one sample at a time
// and produces its results one per cycle, while the result queue is not full,
// into a four-entry result queue. A new sample is taken only after the
// sequencer is done with the previous one. run_last marks the final result
// of each input transaction and chunk_done the final result of a chunk. The
// user must write the phase step through the configuration port only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module linear_interp_resampler
    import lir_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CFG_W-1:0] i_cfg_wr_data,
    input  wire logic             push,
    output logic                  full,
    input  wire t_in_item         i_in_item,
    output logic                  empty,
    input  wire logic             pop,
    output t_out_item             o_out_item
);

    localparam int STEP_W = FRACTION_BITS + 5;

    logic              work_valid;
    logic              work_pop;
    t_in_item          work_item;
    logic [STEP_W-1:0] work_step;
    logic              emit;
    t_out_item         result;
    logic              out_full;

    // Front part: configuration and input queue.
    lir_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_in_item     (i_in_item),
        .o_work_valid  (work_valid),
        .i_work_pop    (work_pop),
        .o_work_item   (work_item),
        .o_work_step   (work_step)
    );

    // Back part: interpolation sequencer.
    lir_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (work_valid),
        .o_work_pop   (work_pop),
        .i_work_item  (work_item),
        .i_work_step  (work_step),
        .o_emit       (emit),
        .o_result     (result),
        .i_out_full   (out_full)
    );

    // Result queue toward the consumer.
    lir_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (emit),
        .i_wr_item  (result),
        .o_full     (out_full),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire
